// File: hdl/pia_pkg.sv
package pia_pkg;

  // width used for all range compares (holds DEPTH up to 511)
  localparam int CMP_W = 9;

  // operation codes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_DISP   = 3'd2;
  localparam logic [2:0] OP_INS    = 3'd3;
  localparam logic [2:0] OP_DEL    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;

  // most entries a display can show (position is 4 bits)
  localparam int DISP_LIMIT = 16;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         position;
    logic signed [31:0] element;
    logic [4:0]         new_size;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         out_position;
    logic signed [31:0] out_value;
    logic               last;
  } result_t;

  // outcome of the admission check for one transaction
  typedef struct packed {
    logic       go;
    logic [2:0] status;
  } chk_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DISP = 4'b0010,
    S_INS  = 4'b0100,
    S_DEL  = 4'b1000
  } state_t;

endpackage

// File: hdl/positional_insert_delete_array.sv
// Positional insert/delete array: an ordered table of up to DEPTH signed words.
// Command channel: cmd (opcode, position, element, new_size) is taken at a
// rising edge with start high and busy low. Result channel: valid marks one
// result per cycle on result (status, out_position, out_value, last); the
// receiver cannot hold results off, so each result is shown for one cycle only.
// Create, load and refused operations: one result, the cycle after the
// transaction; busy stays low. Display: min(count,16) results, one per cycle,
// starting once the first entry has been read; busy until the last read issues.
// Insert: busy while it shifts entries up one per cycle, then writes the element.
// Delete: busy while upper entries shift down; result follows the last shift.
// The speed is set by the entry memory, with one write port and one registered
// read port (one read and one write a cycle), walked by one shared index
// counter. Opcodes 5 to 7 give no result.
// Reset (rst, synchronous) empties the table and clears the target size;
// entry contents are not cleared, only entries below count are ever read.
module positional_insert_delete_array
  import pia_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    valid,
  output result_t result
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int DISP_MAX = (DEPTH < DISP_LIMIT) ? DEPTH : DISP_LIMIT;

  // control registers
  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [4:0]    target_size, target_size_next;
  logic [CW-1:0] idx, idx_next;
  logic          wpend, wpend_next;
  logic          cap, cap_next;
  logic          res_valid, res_valid_next;

  // payload registers
  cmd_t          cmd_q;
  logic [AW-1:0] waddr, waddr_next;
  logic [2:0]    res_status, res_status_next;
  logic [3:0]    res_pos, res_pos_next;
  logic [31:0]   res_value, res_value_next;
  logic          res_last, res_last_next;
  logic          res_ram, res_ram_next;

  // memory port and helpers
  logic          accept;
  chk_t          chk;
  logic          we_dir;
  logic [AW-1:0] waddr_dir;
  logic [31:0]   wdata_dir;
  logic          we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] shown;
  logic [CMP_W-1:0] idx_w;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] count_w;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign idx_m1 = idx - CW'(1);
  assign shown  = (count > CW'(DISP_MAX)) ? CW'(DISP_MAX) : count;
  assign idx_w   = CMP_W'(idx);
  assign pos_w   = CMP_W'(cmd_q.position);
  assign count_w = CMP_W'(count);

  pia_check #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_check (
    .cmd         (cmd),
    .count       (count),
    .target_size (target_size),
    .chk         (chk)
  );

  // pending shift write has priority; direct writes never overlap it
  assign we        = wpend || we_dir;
  assign ram_waddr = wpend ? waddr : waddr_dir;
  assign ram_wdata = wpend ? rdata : wdata_dir;

  pia_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer
  always_comb begin
    state_next       = state;
    count_next       = count;
    target_size_next = target_size;
    idx_next         = idx;
    wpend_next       = 1'b0;
    cap_next         = 1'b0;
    waddr_next       = waddr;
    res_valid_next   = 1'b0;
    res_status_next  = res_status;
    res_pos_next     = res_pos;
    res_value_next   = res_value;
    res_last_next    = res_last;
    res_ram_next     = 1'b0;
    we_dir           = 1'b0;
    waddr_dir        = count[AW-1:0];
    wdata_dir        = cmd.element;
    raddr            = idx[AW-1:0];

    // removed value of a delete arrives in the cycle after its read
    if (cap) begin
      res_value_next = rdata;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            OP_CREATE, OP_LOAD: begin
              res_valid_next  = 1'b1;
              res_status_next = chk.status;
              res_pos_next    = '0;
              res_value_next  = '0;
              res_last_next   = 1'b1;
              if (chk.go && cmd.opcode == OP_CREATE) begin
                target_size_next = cmd.new_size;
                count_next       = '0;
              end
              if (chk.go && cmd.opcode == OP_LOAD) begin
                we_dir         = 1'b1;
                waddr_dir      = count[AW-1:0];
                wdata_dir      = cmd.element;
                count_next     = count + CW'(1);
                res_pos_next   = 4'(count);
                res_value_next = cmd.element;
              end
            end
            OP_DISP, OP_INS, OP_DEL: begin
              if (chk.go) begin
                if (cmd.opcode == OP_DISP) begin
                  state_next = S_DISP;
                  idx_next   = '0;
                end else if (cmd.opcode == OP_INS) begin
                  state_next = S_INS;
                  idx_next   = count;
                end else begin
                  state_next = S_DEL;
                  idx_next   = CW'(cmd.position);
                end
              end else begin
                res_valid_next  = 1'b1;
                res_status_next = chk.status;
                res_pos_next    = '0;
                res_value_next  = '0;
                res_last_next   = 1'b1;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // one read per cycle, result shown as the data returns
      S_DISP: begin
        raddr           = idx[AW-1:0];
        res_valid_next  = 1'b1;
        res_ram_next    = 1'b1;
        res_status_next = ST_OK;
        res_pos_next    = 4'(idx);
        res_last_next   = ((idx + CW'(1)) == shown);
        idx_next        = idx + CW'(1);
        if ((idx + CW'(1)) == shown) begin
          state_next = S_IDLE;
        end
      end

      // walk down from count, moving entry i-1 to i
      S_INS: begin
        if (idx_w > pos_w) begin
          raddr      = idx_m1[AW-1:0];
          wpend_next = 1'b1;
          waddr_next = idx[AW-1:0];
          idx_next   = idx_m1;
        end else if (!wpend) begin
          we_dir          = 1'b1;
          waddr_dir       = cmd_q.position[AW-1:0];
          wdata_dir       = cmd_q.element;
          count_next      = count + CW'(1);
          res_valid_next  = 1'b1;
          res_status_next = ST_OK;
          res_pos_next    = '0;
          res_value_next  = '0;
          res_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      // walk up from position, moving entry i to i-1
      S_DEL: begin
        if (idx_w < count_w) begin
          raddr      = idx[AW-1:0];
          cap_next   = (idx_w == pos_w);
          wpend_next = (idx_w > pos_w);
          waddr_next = idx_m1[AW-1:0];
          idx_next   = idx + CW'(1);
        end else if (!wpend && !cap) begin
          count_next      = count - CW'(1);
          res_valid_next  = 1'b1;
          res_status_next = ST_OK;
          res_pos_next    = cmd_q.position;
          res_last_next   = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      target_size <= '0;
      idx         <= '0;
      wpend       <= 1'b0;
      cap         <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      count       <= count_next;
      target_size <= target_size_next;
      idx         <= idx_next;
      wpend       <= wpend_next;
      cap         <= cap_next;
      res_valid   <= res_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    waddr      <= waddr_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_value  <= res_value_next;
    res_last   <= res_last_next;
    res_ram    <= res_ram_next;
  end

  // result transaction
  assign valid               = res_valid;
  assign result.status       = res_status;
  assign result.out_position = res_pos;
  assign result.out_value    = res_ram ? rdata : res_value;
  assign result.last         = res_last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(wpend && we_dir))
    else $error("shift write collides with direct write");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!wpend && !cap))
    else $error("shift still pending when idle");

  a_create_result: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_CREATE) |=> (valid && result.last))
    else $error("create gave no final result");

endmodule

// File: hdl/pia_check.sv
module pia_check
  import pia_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  cmd_t          cmd,
  input  logic [CW-1:0] count,
  input  logic [4:0]    target_size,
  output chk_t          chk
);

  logic [CMP_W-1:0] count_w;
  logic [CMP_W-1:0] tgt_w;
  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] nsz_w;
  logic [CMP_W-1:0] depth_w;

  assign count_w = CMP_W'(count);
  assign tgt_w   = CMP_W'(target_size);
  assign pos_w   = CMP_W'(cmd.position);
  assign nsz_w   = CMP_W'(cmd.new_size);
  assign depth_w = CMP_W'(DEPTH);

  // decode opcode into go / status
  always_comb begin
    chk.go     = 1'b0;
    chk.status = ST_OK;
    unique case (cmd.opcode)
      OP_CREATE: begin
        chk.go     = !(nsz_w > depth_w);
        chk.status = chk.go ? ST_OK : ST_TOO_LARGE;
      end
      OP_LOAD: begin
        chk.go     = (count_w < tgt_w) && (count_w < depth_w);
        chk.status = chk.go ? ST_OK : ST_RANGE;
      end
      OP_DISP: begin
        chk.go     = (count_w != '0);
        chk.status = chk.go ? ST_OK : ST_EMPTY;
      end
      OP_INS: begin
        if (count_w == '0) begin
          chk.status = ST_EMPTY;
        end else if (count_w >= depth_w) begin
          chk.status = ST_FULL;
        end else if (pos_w >= count_w) begin
          chk.status = ST_RANGE;
        end else begin
          chk.go = 1'b1;
        end
      end
      OP_DEL: begin
        if (count_w == '0) begin
          chk.status = ST_EMPTY;
        end else if (pos_w >= count_w) begin
          chk.status = ST_RANGE;
        end else begin
          chk.go = 1'b1;
        end
      end
      default: begin
        chk.go     = 1'b0;
        chk.status = ST_OK;
      end
    endcase
  end

endmodule

// File: hdl/pia_ram.sv
module pia_ram
  import pia_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: tb/positional_insert_delete_array_test.sv
module positional_insert_delete_array_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pia_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam int MAX_PRINTED = 50;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    valid;
  result_t result;

  // scoreboard state
  result_t expected_results[$];
  int      error_count = 0;
  int      results_checked = 0;
  int      accepted_count = 0;
  int      op_seen[8];
  bit      gaps_on = 1'b1;

  // shadow copy of the table
  logic signed [31:0] held_words[TABLE_DEPTH];
  int held_count = 0;
  int size_goal = 0;

  positional_insert_delete_array #(.DEPTH(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .valid(valid),
    .result(result)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("%0t ns  mismatch: %s", $time, msg);
    end
    error_count++;
  endtask

  // work out the results one accepted transaction must produce
  task automatic predict_results(input cmd_t c);
    result_t r;
    int shown;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (c.opcode)
      OP_CREATE: begin
        if (c.new_size > TABLE_DEPTH) begin
          r.status = ST_TOO_LARGE;
        end else begin
          size_goal = c.new_size;
          held_count = 0;
        end
      end
      OP_LOAD: begin
        if (held_count < size_goal && held_count < TABLE_DEPTH) begin
          held_words[held_count] = c.element;
          r.out_position = 4'(held_count);
          r.out_value = c.element;
          held_count++;
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_DISP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shown = (held_count > DISP_LIMIT) ? DISP_LIMIT : held_count;
          for (int i = 0; i < shown; i++) begin
            r.out_position = 4'(i);
            r.out_value = held_words[i];
            r.last = (i == shown - 1);
            expected_results.push_back(r);
          end
          return;
        end
      end
      OP_INS: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (held_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (c.position >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = held_count; i > c.position; i--) begin
            held_words[i] = held_words[i-1];
          end
          held_words[c.position] = c.element;
          held_count++;
        end
      end
      OP_DEL: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else if (c.position >= held_count) begin
          r.status = ST_RANGE;
        end else begin
          r.out_position = c.position;
          r.out_value = held_words[c.position];
          for (int i = c.position; i + 1 < held_count; i++) begin
            held_words[i] = held_words[i+1];
          end
          held_count--;
        end
      end
      default: return;
    endcase
    expected_results.push_back(r);
  endtask

  // check every result against the oldest expectation
  result_t want;
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d pos=%0d value=%0d last=%0b",
                                  result.status, result.out_position, result.out_value,
                                  result.last));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
        if (result.out_position !== want.out_position)
          report_mismatch($sformatf("out_position %0d, want %0d",
                                    result.out_position, want.out_position));
        if (result.out_value !== want.out_value)
          report_mismatch($sformatf("out_value %0d, want %0d",
                                    result.out_value, want.out_value));
        if (result.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", result.last, want.last));
      end
    end
  end

  // send one transaction; called and returns at a falling edge
  task automatic issue_cmd(input logic [2:0] op, input logic [3:0] pos,
                           input logic signed [31:0] elem, input logic [4:0] nsz);
    cmd_t c;
    c.opcode = op;
    c.position = pos;
    c.element = elem;
    c.new_size = nsz;
    while (gaps_on && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    predict_results(c);
    accepted_count++;
    op_seen[op]++;
    @(negedge clk);
  endtask

  // hold the sender off until every expected result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // mostly an existing position, sometimes anywhere
  function automatic logic [3:0] pick_position();
    if (held_count > 0 && $urandom_range(99) < 80) return 4'($urandom_range(held_count - 1));
    return 4'($urandom);
  endfunction

  // refusals on an empty table and oversize creates
  task automatic test_empty_table();
    issue_cmd(OP_CREATE, '0, '0, 5'(TABLE_DEPTH + 1));
    issue_cmd(OP_CREATE, '0, '0, 5'd31);
    issue_cmd(OP_CREATE, '0, '0, 5'd0);
    issue_cmd(OP_LOAD, '0, pick_word(), '0);
    issue_cmd(OP_DISP, '0, '0, '0);
    issue_cmd(OP_INS, '0, pick_word(), '0);
    issue_cmd(OP_DEL, '0, '0, '0);
  endtask

  // fill to the top, then edits at both ends
  task automatic test_full_table();
    issue_cmd(OP_CREATE, '0, '0, 5'(TABLE_DEPTH));
    issue_cmd(OP_LOAD, '0, 32'sh8000_0000, '0);
    issue_cmd(OP_LOAD, '0, 32'sh7fff_ffff, '0);
    issue_cmd(OP_LOAD, '0, -32'sd1, '0);
    issue_cmd(OP_LOAD, '0, '0, '0);
    for (int i = 4; i < TABLE_DEPTH; i++) issue_cmd(OP_LOAD, '0, $urandom, '0);
    issue_cmd(OP_LOAD, '0, pick_word(), '0);
    issue_cmd(OP_INS, '0, pick_word(), '0);
    issue_cmd(OP_DISP, '0, '0, '0);
    issue_cmd(OP_DEL, 4'd15, '0, '0);
    issue_cmd(OP_DEL, 4'd15, '0, '0);
    issue_cmd(OP_INS, 4'd15, pick_word(), '0);
    issue_cmd(OP_INS, 4'd0, 32'sh7fff_ffff, '0);
    issue_cmd(OP_DEL, 4'd0, '0, '0);
  endtask

  // codes above delete must be ignored
  task automatic test_unknown_opcodes();
    for (logic [3:0] op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      issue_cmd(op[2:0], 4'($urandom), $urandom, 5'($urandom));
    issue_cmd(OP_DISP, '0, '0, '0);
  endtask

  // create, load, then a random run of edits, over and over
  task automatic test_random_sessions(input int item_goal);
    int issued;
    int sessions;
    int sz;
    int fills;
    int edits;
    int pick;
    logic [2:0] op;
    issued = 0;
    sessions = 0;
    while (issued < item_goal) begin
      gaps_on = !(issued >= 50 && issued < 95);
      sz = ($urandom_range(9) == 0) ? $urandom_range(TABLE_DEPTH + 1, 31)
                                     : $urandom_range(TABLE_DEPTH);
      issue_cmd(OP_CREATE, 4'($urandom), $urandom, 5'(sz));
      issued++;
      fills = (sz > TABLE_DEPTH) ? $urandom_range(2) : sz;
      if ($urandom_range(4) == 0) fills = fills + 1;
      else if ($urandom_range(4) == 0 && fills > 0) fills = $urandom_range(fills);
      for (int i = 0; i < fills; i++) begin
        issue_cmd(OP_LOAD, 4'($urandom), pick_word(), 5'($urandom));
        issued++;
      end
      edits = $urandom_range(4, 14);
      for (int i = 0; i < edits; i++) begin
        pick = $urandom_range(99);
        if (pick < 18) op = OP_DISP;
        else if (pick < 45) op = OP_INS;
        else if (pick < 75) op = OP_DEL;
        else if (pick < 85) op = OP_LOAD;
        else if (pick < 92) op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        else op = 3'($urandom);
        issue_cmd(op, pick_position(), pick_word(), 5'($urandom));
        if (op <= OP_DEL) issued++;
      end
      sessions++;
      if (sessions % 4 == 0) drain_results();
    end
  endtask

  initial begin
    int guard;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_table();
    drain_results();
    test_full_table();
    drain_results();
    test_unknown_opcodes();
    test_random_sessions(130);

    // let the last results come back
    start <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));

    $display("covered %0d transactions: %0d create, %0d load, %0d display, %0d insert, %0d delete",
             accepted_count, op_seen[OP_CREATE], op_seen[OP_LOAD], op_seen[OP_DISP],
             op_seen[OP_INS], op_seen[OP_DEL]);
    $display("%0d results checked, %0d ignored opcodes sent, %0d mismatches",
             results_checked, op_seen[5] + op_seen[6] + op_seen[7], error_count);
    if (error_count == 0) begin
      $display("positional_insert_delete_array regression: pass");
    end else begin
      $display("positional_insert_delete_array regression: fail");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #5ms;
    $display("timeout waiting on the block");
    $display("positional_insert_delete_array regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/pia_pkg.sv
hdl/pia_check.sv
hdl/pia_ram.sv
hdl/positional_insert_delete_array.sv
tb/positional_insert_delete_array_test.sv
